// ===== src/cbad_pkg.sv =====
// Package with the constants, codes and tables of the console bus address decoder.
`default_nettype none
package cbad_pkg;

    localparam int RAM_BANKS  = 32;
    localparam int BIOS_BANKS = 8;

    localparam int BANK_W    = 5;
    localparam int RAM_SEG_N = 128;

    typedef enum logic [2:0] {
        TGT_NONE    = 3'd0,
        TGT_RAM     = 3'd1,
        TGT_PPORT   = 3'd2,
        TGT_SCRATCH = 3'd3,
        TGT_HWREG   = 3'd4,
        TGT_BIOS    = 3'd5
    } t_target;

    typedef enum logic [1:0] {
        ST_ROUTED   = 2'd0,
        ST_UNMAPPED = 2'd1,
        ST_DROPPED  = 2'd2,
        ST_ISOCTRL  = 2'd3
    } t_status;

    localparam logic [31:0] ISO_CTRL_ADDR = 32'hfffe_0130;
    localparam logic [31:0] ISO_SET_A     = 32'h0000_0800;
    localparam logic [31:0] ISO_SET_B     = 32'h0000_0804;
    localparam logic [31:0] ISO_CLR_A     = 32'h0000_0000;
    localparam logic [31:0] ISO_CLR_B     = 32'h0001_e988;

    localparam logic [15:0] SCRATCH_LIMIT = 16'h1000;
    localparam logic [15:0] SEG_SCR_K0    = 16'h1f80;
    localparam logic [15:0] SEG_SCR_K1    = 16'h9f80;
    localparam logic [15:0] SEG_SCR_K2    = 16'hbf80;
    localparam logic [15:0] SEG_PPORT     = 16'h1f00;
    localparam logic [11:0] SEG_BIOS_HI   = 12'hbfc;
    localparam logic [8:0]  SEG_RAM_KU    = 9'h000;
    localparam logic [8:0]  SEG_RAM_K0    = 9'h100;
    localparam logic [8:0]  SEG_RAM_K1    = 9'h140;

    localparam logic [1:0]  SIZE_WORD     = 2'd2;

    typedef logic [RAM_SEG_N-1:0][BANK_W-1:0] t_bank_tbl;

    function automatic t_bank_tbl build_bank_tbl();
        t_bank_tbl tbl;
        for (int i = 0; i < RAM_SEG_N; i++) begin
            tbl[i] = BANK_W'(i % RAM_BANKS);
        end
        return tbl;
    endfunction

    localparam t_bank_tbl RAM_BANK_TBL = build_bank_tbl();

endpackage
`default_nettype wire

// ===== src/console_bus_address_decoder_top.sv =====
// Top level of the console bus address decoder.
// Each input transaction is one bus access: read or write, its size, a 32-bit
// address and the store data. The block decodes the address into a target
// and a byte offset, reports whether the access is routed, unmapped or
// dropped, keeps the cache-isolation flag and flags code cache invalidates.
// Both channels use valid and stall; a transaction moves at a rising edge at
// which valid is high and stall is low.
// An accepted transaction is held in the input register and its result is
// loaded into the output register, which offers it to the receiver. One
// transaction is accepted every cycle while input stall is low; the input
// register and the output register form a two-stage pipe.
// When the receiver stalls, the result is held and the input register keeps
// its transaction; input stall rises only when both stages are full.
// A synchronous active-low reset empties both stages and clears the
// isolation flag, so writes to main RAM are enabled after reset.
`default_nettype none
module console_bus_address_decoder_top
    import cbad_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_req_type,
    input  wire logic [1:0]  i_access_size,
    input  wire logic [31:0] i_bus_address,
    input  wire logic [31:0] i_write_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_target,
    output logic [20:0]      o_target_offset,
    output logic [1:0]       o_status,
    output logic             o_cache_isolated,
    output logic             o_invalidate,
    output logic [31:0]      o_invalidate_address
);

    logic        r_s1_valid;
    logic        r_req_type;
    logic [1:0]  r_access_size;
    logic [31:0] r_bus_address;
    logic [31:0] r_write_data;
    logic        r_iso;

    logic        r_out_valid;
    logic [2:0]  r_target;
    logic [20:0] r_offset;
    logic [1:0]  r_status;
    logic        r_cache_isolated;
    logic        r_invalidate;
    logic [31:0] r_inval_addr;

    logic        adv;
    logic        load_s1;

    logic [15:0] seg;
    logic [15:0] low;
    logic        word;
    logic        is_scr_seg;
    logic        is_ram_seg;
    logic        is_bios_seg;

    t_target     n_target;
    logic [20:0] n_offset;
    t_status     n_status;
    logic        n_iso;
    logic        n_invalidate;
    logic [31:0] n_inval_addr;

    assign adv        = !(r_out_valid && i_out_stall);
    assign load_s1    = adv || !r_s1_valid;
    assign o_in_stall = !load_s1;

    assign seg  = r_bus_address[31:16];
    assign low  = r_bus_address[15:0];
    assign word = (r_access_size >= SIZE_WORD);

    assign is_scr_seg  = (seg == SEG_SCR_K0) || (seg == SEG_SCR_K1) || (seg == SEG_SCR_K2);
    assign is_ram_seg  = (seg[15:7] == SEG_RAM_KU) || (seg[15:7] == SEG_RAM_K0)
                      || (seg[15:7] == SEG_RAM_K1);
    assign is_bios_seg = (seg[15:4] == SEG_BIOS_HI) && ({1'b0, seg[3:0]} < 5'(BIOS_BANKS));

    always_comb begin
        n_target     = TGT_NONE;
        n_offset     = '0;
        n_status     = ST_ROUTED;
        n_iso        = r_iso;
        n_invalidate = 1'b0;
        n_inval_addr = '0;

        if (is_scr_seg) begin
            n_target = (low < SCRATCH_LIMIT) ? TGT_SCRATCH : TGT_HWREG;
            n_offset = {5'd0, low};
        end else if (is_ram_seg) begin
            n_target = TGT_RAM;
            n_offset = {RAM_BANK_TBL[seg[6:0]], low};
        end else if (seg == SEG_PPORT) begin
            n_target = TGT_PPORT;
            n_offset = {5'd0, low};
        end else if (is_bios_seg) begin
            n_target = TGT_BIOS;
            n_offset = {1'b0, seg[3:0], low};
        end

        if (!r_req_type) begin
            if (n_target == TGT_NONE) begin
                n_status = ST_UNMAPPED;
            end
        end else if (n_target == TGT_SCRATCH || n_target == TGT_HWREG) begin
            n_status = ST_ROUTED;
        end else if (n_target == TGT_PPORT || (n_target == TGT_RAM && !r_iso)) begin
            n_invalidate = 1'b1;
            n_inval_addr = word ? r_bus_address : {r_bus_address[31:2], 2'b00};
        end else begin
            n_target = TGT_NONE;
            n_offset = '0;
            if (word && r_bus_address == ISO_CTRL_ADDR) begin
                n_status = ST_ISOCTRL;
                if (r_write_data == ISO_SET_A || r_write_data == ISO_SET_B) begin
                    n_iso = 1'b1;
                end else if (r_write_data == ISO_CLR_A || r_write_data == ISO_CLR_B) begin
                    n_iso = 1'b0;
                end
            end else begin
                n_status = ST_DROPPED;
                if (word && r_iso) begin
                    n_invalidate = 1'b1;
                    n_inval_addr = r_bus_address;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_iso       <= 1'b0;
        end else begin
            if (load_s1) begin
                r_s1_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_iso <= n_iso;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s1 && i_in_valid) begin
            r_req_type    <= i_req_type;
            r_access_size <= i_access_size;
            r_bus_address <= i_bus_address;
            r_write_data  <= i_write_data;
        end
        if (adv && r_s1_valid) begin
            r_target         <= n_target;
            r_offset         <= n_offset;
            r_status         <= n_status;
            r_cache_isolated <= n_iso;
            r_invalidate     <= n_invalidate;
            r_inval_addr     <= n_inval_addr;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_target             = r_target;
    assign o_target_offset      = r_offset;
    assign o_status             = r_status;
    assign o_cache_isolated     = r_cache_isolated;
    assign o_invalidate         = r_invalidate;
    assign o_invalidate_address = r_inval_addr;

`ifndef SYNTH
    a_iso_matches_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cache_isolated == r_iso))
        else $error("offered isolation flag differs from the stored flag");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && o_out_valid && i_out_stall))
        else $error("input stalled while the pipe has room");

    a_isoctrl_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_ISOCTRL) |->
            (o_target == TGT_NONE && !o_invalidate && o_target_offset == '0))
        else $error("isolation control transaction routed or invalidating");

    a_inval_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_invalidate) |->
            (o_target == TGT_RAM || o_target == TGT_PPORT || o_status == ST_DROPPED))
        else $error("invalidate raised for a target that cannot hold code");

    a_isoctrl_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && adv && n_status != ST_ISOCTRL) |=> (r_iso == $past(r_iso)))
        else $error("isolation flag changed outside a control write");
`endif

endmodule
`default_nettype wire

// ===== test/cbad_decode_checker.sv =====
// Checker that predicts the decode of every accepted bus access and compares it with the results.
`timescale 1ns / 100ps
module cbad_decode_checker
    import cbad_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic        i_req_type,
    input  wire logic [1:0]  i_access_size,
    input  wire logic [31:0] i_bus_address,
    input  wire logic [31:0] i_write_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [2:0]  i_target,
    input  wire logic [20:0] i_target_offset,
    input  wire logic [1:0]  i_status,
    input  wire logic        i_cache_isolated,
    input  wire logic        i_invalidate,
    input  wire logic [31:0] i_invalidate_address,
    output int               o_error_count,
    output int               o_pending
);

    typedef struct packed {
        t_target     target;
        logic [20:0] offset;
        t_status     status;
        logic        isolated;
        logic        invalidate;
        logic [31:0] invalidate_address;
    } t_decode;

    t_decode expected_decodes[$];
    logic    isolated;

    function automatic t_decode decode_access(input logic is_write, input logic [1:0] size,
                                              input logic [31:0] addr, input logic [31:0] data,
                                              input logic iso);
        t_decode     d;
        logic [15:0] seg;
        logic [15:0] low;
        logic        word;
        seg  = addr[31:16];
        low  = addr[15:0];
        word = size[1];
        d.target             = TGT_NONE;
        d.offset             = '0;
        d.status             = ST_ROUTED;
        d.isolated           = iso;
        d.invalidate         = 1'b0;
        d.invalidate_address = '0;

        if (seg == SEG_SCR_K0 || seg == SEG_SCR_K1 || seg == SEG_SCR_K2) begin
            d.target = (low < SCRATCH_LIMIT) ? TGT_SCRATCH : TGT_HWREG;
            d.offset = {5'd0, low};
        end else if (seg[15:7] == SEG_RAM_KU || seg[15:7] == SEG_RAM_K0
                     || seg[15:7] == SEG_RAM_K1) begin
            d.target = TGT_RAM;
            d.offset = {BANK_W'(int'(seg[6:0]) % RAM_BANKS), low};
        end else if (seg == SEG_PPORT) begin
            d.target = TGT_PPORT;
            d.offset = {5'd0, low};
        end else if (seg[15:4] == SEG_BIOS_HI && int'(seg[3:0]) < BIOS_BANKS) begin
            d.target = TGT_BIOS;
            d.offset = {1'b0, seg[3:0], low};
        end

        if (!is_write) begin
            if (d.target == TGT_NONE) begin
                d.status = ST_UNMAPPED;
            end
        end else if (d.target == TGT_SCRATCH || d.target == TGT_HWREG) begin
            d.status = ST_ROUTED;
        end else if (d.target == TGT_PPORT || (d.target == TGT_RAM && !iso)) begin
            d.invalidate         = 1'b1;
            d.invalidate_address = word ? addr : {addr[31:2], 2'b00};
        end else begin
            d.target = TGT_NONE;
            d.offset = '0;
            if (word && addr == ISO_CTRL_ADDR) begin
                d.status = ST_ISOCTRL;
                if (data == ISO_SET_A || data == ISO_SET_B) begin
                    d.isolated = 1'b1;
                end else if (data == ISO_CLR_A || data == ISO_CLR_B) begin
                    d.isolated = 1'b0;
                end
            end else begin
                d.status = ST_DROPPED;
                if (word && iso) begin
                    d.invalidate         = 1'b1;
                    d.invalidate_address = addr;
                end
            end
        end
        return d;
    endfunction

    function automatic int field_differs(input string name, input logic [31:0] expv,
                                         input logic [31:0] actv);
        if (expv !== actv) begin
            $error("%s expected 0x%0h got 0x%0h", name, expv, actv);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        int      bad;
        t_decode oldest;
        t_decode predicted;
        bad = 0;
        if (!i_rst_n) begin
            expected_decodes.delete();
            isolated      <= 1'b0;
            o_error_count <= 0;
            o_pending     <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_decodes.size() == 0) begin
                    $error("Result transaction arrived with no access outstanding.");
                    bad = 1;
                end else begin
                    oldest = expected_decodes.pop_front();
                    bad += field_differs("target", 32'(oldest.target), 32'(i_target));
                    bad += field_differs("target_offset", 32'(oldest.offset),
                                         32'(i_target_offset));
                    bad += field_differs("status", 32'(oldest.status), 32'(i_status));
                    bad += field_differs("cache_isolated", 32'(oldest.isolated),
                                         32'(i_cache_isolated));
                    bad += field_differs("invalidate", 32'(oldest.invalidate),
                                         32'(i_invalidate));
                    bad += field_differs("invalidate_address", oldest.invalidate_address,
                                         i_invalidate_address);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predicted = decode_access(i_req_type, i_access_size, i_bus_address,
                                          i_write_data, isolated);
                expected_decodes.push_back(predicted);
                isolated <= predicted.isolated;
            end
            o_error_count <= o_error_count + bad;
            o_pending     <= expected_decodes.size();
        end
    end

endmodule

// ===== test/console_bus_address_decoder_top_tb.sv =====
// Testbench top that drives bus accesses into the decoder and gives the verdict.
`timescale 1ns / 100ps
module console_bus_address_decoder_top_tb
    import cbad_pkg::*;
();

    localparam int RANDOM_ACCESSES  = 800;
    localparam int LONG_HOLD_CYCLES = 300;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        i_req_type    = 1'b0;
    logic [1:0]  i_access_size = 2'd0;
    logic [31:0] i_bus_address = 32'd0;
    logic [31:0] i_write_data  = 32'd0;
    logic        i_out_stall   = 1'b0;

    wire logic        o_in_stall;
    wire logic        o_out_valid;
    wire logic [2:0]  o_target;
    wire logic [20:0] o_target_offset;
    wire logic [1:0]  o_status;
    wire logic        o_cache_isolated;
    wire logic        o_invalidate;
    wire logic [31:0] o_invalidate_address;

    int error_count;
    int pending;
    bit quiet_tail    = 1'b0;
    bit long_hold_req = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    console_bus_address_decoder_top DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_req_type           (i_req_type),
        .i_access_size        (i_access_size),
        .i_bus_address        (i_bus_address),
        .i_write_data         (i_write_data),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_target             (o_target),
        .o_target_offset      (o_target_offset),
        .o_status             (o_status),
        .o_cache_isolated     (o_cache_isolated),
        .o_invalidate         (o_invalidate),
        .o_invalidate_address (o_invalidate_address)
    );

    cbad_decode_checker decode_check (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_in_stall           (o_in_stall),
        .i_req_type           (i_req_type),
        .i_access_size        (i_access_size),
        .i_bus_address        (i_bus_address),
        .i_write_data         (i_write_data),
        .i_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .i_target             (o_target),
        .i_target_offset      (o_target_offset),
        .i_status             (o_status),
        .i_cache_isolated     (o_cache_isolated),
        .i_invalidate         (o_invalidate),
        .i_invalidate_address (o_invalidate_address),
        .o_error_count        (error_count),
        .o_pending            (pending)
    );

    task automatic send_access(input logic wr, input logic [1:0] size,
                               input logic [31:0] addr, input logic [31:0] data);
        i_in_valid    <= 1'b1;
        i_req_type    <= wr;
        i_access_size <= size;
        i_bus_address <= addr;
        i_write_data  <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Most accesses land in mapped regions or just past their edges.
    function automatic logic [31:0] pick_address();
        logic [15:0] seg;
        logic [15:0] low;
        logic [15:0] ram_base;
        int          roll;
        roll     = $urandom_range(0, 9);
        low      = 16'($urandom);
        ram_base = ($urandom_range(0, 2) == 0) ? 16'h0000 :
                   ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'ha000;
        case (roll)
            0, 1, 2: seg = ram_base | 16'($urandom_range(0, 127));
            3: begin
                seg = ($urandom_range(0, 2) == 0) ? SEG_SCR_K0 :
                      ($urandom_range(0, 1) == 0) ? SEG_SCR_K1 : SEG_SCR_K2;
                low = 16'($urandom_range(0, 16'h0fff));
            end
            4: seg = ($urandom_range(0, 2) == 0) ? SEG_SCR_K0 :
                     ($urandom_range(0, 1) == 0) ? SEG_SCR_K1 : SEG_SCR_K2;
            5: seg = SEG_PPORT;
            6: seg = {SEG_BIOS_HI, 4'($urandom_range(0, 15))};
            7: return ISO_CTRL_ADDR;
            8: seg = 16'($urandom);
            default: seg = ram_base + 16'($urandom_range(16'h0080, 16'h00ff));
        endcase
        return {seg, low};
    endfunction

    function automatic logic [31:0] pick_data(input logic [31:0] addr);
        if (addr != ISO_CTRL_ADDR) begin
            return $urandom;
        end
        case ($urandom_range(0, 4))
            0: return ISO_SET_A;
            1: return ISO_SET_B;
            2: return ISO_CLR_A;
            3: return ISO_CLR_B;
            default: return $urandom;
        endcase
    endfunction

    initial begin : receiver
        int stretch;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                stretch = $urandom_range(1, 12);
                i_out_stall <= 1'b1;
                repeat (stretch) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        logic [31:0] addr;
        logic [1:0]  size;
        logic        wr;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_access(1'b0, 2'd0, 32'h0000_0000, 32'h0000_0000);
        send_access(1'b1, 2'd1, 32'h801f_ffff, 32'hffff_ffff);
        send_access(1'b1, 2'd2, 32'ha07f_fffe, 32'h5a5a_a5a5);
        send_access(1'b0, 2'd2, 32'h0080_0000, 32'h0000_0000);
        send_access(1'b1, 2'd2, 32'hffff_ffff, 32'hffff_ffff);
        send_access(1'b0, 2'd0, 32'h1f80_0000, 32'h0000_0000);
        send_access(1'b1, 2'd1, 32'h9f80_0fff, 32'h1234_5678);
        send_access(1'b1, 2'd2, 32'hbf80_1000, 32'h8765_4321);
        send_access(1'b0, 2'd2, 32'h1f80_ffff, 32'h0000_0000);
        send_access(1'b1, 2'd0, 32'h1f00_0003, 32'h0000_00ff);
        send_access(1'b0, 2'd1, 32'h1f00_fffe, 32'h0000_0000);
        send_access(1'b0, 2'd2, 32'hbfc0_0000, 32'h0000_0000);
        send_access(1'b0, 2'd0, 32'hbfc7_ffff, 32'h0000_0000);
        send_access(1'b1, 2'd2, 32'hbfc0_0010, 32'hdead_beef);
        send_access(1'b0, 2'd2, 32'hbfc8_0000, 32'h0000_0000);
        // Isolate the cache, then exercise the writes that isolation affects.
        send_access(1'b1, 2'd2, ISO_CTRL_ADDR, ISO_SET_A);
        send_access(1'b1, 2'd2, 32'h0001_2344, 32'hcafe_f00d);
        send_access(1'b1, 2'd0, 32'h8000_0007, 32'h0000_0011);
        send_access(1'b1, 2'd1, 32'h1f00_0002, 32'h0000_2222);
        send_access(1'b1, 2'd0, ISO_CTRL_ADDR, ISO_CLR_A);
        send_access(1'b1, 2'd2, ISO_CTRL_ADDR, 32'h0001_2345);
        send_access(1'b1, 2'd2, ISO_CTRL_ADDR, ISO_CLR_B);
        send_access(1'b1, 2'd2, ISO_CTRL_ADDR, ISO_SET_B);
        send_access(1'b1, 2'd2, ISO_CTRL_ADDR, ISO_CLR_A);
        send_access(1'b1, 2'd3, 32'h0000_0003, 32'h0f0f_0f0f);

        for (int n = 0; n < RANDOM_ACCESSES; n++) begin
            if (n == 250) begin
                long_hold_req = 1'b1;
            end
            if (n == 500) begin
                wait_drained();
            end
            if (n == RANDOM_ACCESSES - 100) begin
                quiet_tail = 1'b1;
            end
            addr = pick_address();
            wr   = ($urandom_range(0, 9) < 6);
            size = 2'($urandom_range(0, 2));
            if (addr == ISO_CTRL_ADDR && $urandom_range(0, 3) != 0) begin
                wr   = 1'b1;
                size = SIZE_WORD;
            end
            send_access(wr, size, addr, pick_data(addr));
            sender_gap();
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
